### design/assert_macros.svh
// Assertion macros used by the classifier unit design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	`ASSERT_CLK(lbl, clk, rst_n, !(cond))
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

### design/tbcc_pkg.sv
package tbcc_pkg;

	localparam int MAX_SAMPLE = 4096;
	localparam int BYTE_W     = 8;
	localparam int SL_W       = 13;
	localparam int THR_W      = 7;
	localparam int CNT_W      = $clog2(MAX_SAMPLE + 1);
	localparam int LIM_W      = (CNT_W > SL_W) ? CNT_W : SL_W;
	localparam int PROD_W     = CNT_W + THR_W;
	localparam int OUT_W      = ((2 + 2 * CNT_W + 7) / 8) * 8;
	localparam int PCT_SCALE  = 100;

	localparam logic [SL_W-1:0]  SAMPLE_LIMIT_RST = SL_W'(512);
	localparam logic [THR_W-1:0] THRESHOLD_RST    = THR_W'(30);

	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_SAMPLE_LIMIT = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_THRESHOLD    = 1'b1;

	localparam logic [BYTE_W-1:0] CH_NUL        = 8'h00;
	localparam logic [BYTE_W-1:0] CH_TAB        = 8'h09;
	localparam logic [BYTE_W-1:0] CH_LF         = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR         = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_CTRL_END   = 8'h20;
	localparam logic [BYTE_W-1:0] CH_HIGH       = 8'h80;
	localparam logic [BYTE_W-1:0] CONT_MASK     = 8'hC0;
	localparam logic [BYTE_W-1:0] CONT_VAL      = 8'h80;
	localparam logic [BYTE_W-1:0] LEAD2_MASK    = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD2_VAL     = 8'hC0;
	localparam logic [BYTE_W-1:0] LEAD3_MASK    = 8'hF0;
	localparam logic [BYTE_W-1:0] LEAD3_VAL     = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD4_MASK    = 8'hF8;
	localparam logic [BYTE_W-1:0] LEAD4_VAL     = 8'hF0;

	typedef struct packed {
		logic [CNT_W-1:0] examined;
		logic [CNT_W-1:0] nonprint;
		logic [1:0]       pending;
		logic             run_bad;
		logic             null_seen;
	} stream_state_t;

endpackage

### design/tbcc_byte_step.sv
module tbcc_byte_step (
	input  tbcc_pkg::stream_state_t       st,
	input  logic [tbcc_pkg::BYTE_W-1:0]   data_byte,
	input  logic                          byte_present,
	input  logic                          last_byte,
	input  logic [tbcc_pkg::LIM_W-1:0]    limit,
	output tbcc_pkg::stream_state_t       st_done,
	output tbcc_pkg::stream_state_t       st_next
);
	import tbcc_pkg::*;

	logic take;
	logic count_ev;

	assign take = byte_present && (LIM_W'(st.examined) < limit);

	always_comb begin
		st_done  = st;
		count_ev = 1'b0;
		if (take) begin
			st_done.examined = st.examined + CNT_W'(1);
			if (st.pending != 2'd0) begin
				st_done.pending = st.pending - 2'd1;
				if (((data_byte & CONT_MASK) != CONT_VAL) && !st.run_bad) begin
					st_done.run_bad = 1'b1;
					count_ev = 1'b1;
				end
			end else begin
				st_done.run_bad = 1'b0;
				if (data_byte == CH_NUL) begin
					st_done.null_seen = 1'b1;
				end else if (data_byte < CH_CTRL_END) begin
					count_ev = (data_byte != CH_TAB) && (data_byte != CH_LF) &&
						(data_byte != CH_CR);
				end else if (data_byte < CH_HIGH) begin
					count_ev = 1'b0;
				end else if ((data_byte & LEAD2_MASK) == LEAD2_VAL) begin
					st_done.pending = 2'd1;
				end else if ((data_byte & LEAD3_MASK) == LEAD3_VAL) begin
					st_done.pending = 2'd2;
				end else if ((data_byte & LEAD4_MASK) == LEAD4_VAL) begin
					st_done.pending = 2'd3;
				end else begin
					count_ev = 1'b1;
				end
			end
			if (count_ev && !st.null_seen) begin
				st_done.nonprint = st.nonprint + CNT_W'(1);
			end
		end
	end

	always_comb begin
		if (last_byte) begin
			st_next = '0;
		end else begin
			st_next = st_done;
		end
	end

endmodule

### design/tbcc_verdict.sv
module tbcc_verdict (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  tbcc_pkg::stream_state_t         in_state,
	input  logic [tbcc_pkg::THR_W-1:0]      threshold,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [tbcc_pkg::OUT_W-1:0]      m_tdata
);
	import tbcc_pkg::*;

	logic                 v_s2;
	stream_state_t        st_s2;
	logic [THR_W-1:0]     thr_s2;
	logic                 v_s3;
	logic                 null_s3;
	logic                 ex_zero_s3;
	logic [CNT_W-1:0]     np_s3;
	logic [CNT_W-1:0]     ex_s3;
	logic [PROD_W-1:0]    lhs_s3;
	logic [PROD_W-1:0]    rhs_s3;
	logic                 m_valid_q;
	logic [OUT_W-1:0]     m_data_q;
	logic                 adv_s2;
	logic                 adv_s3;
	logic                 text;

	assign adv_s3   = v_s3 && (!m_valid_q || m_tready);
	assign adv_s2   = v_s2 && (!v_s3 || adv_s3);
	assign in_ready = !v_s2 || adv_s2;
	assign text     = !null_s3 && (ex_zero_s3 || (lhs_s3 < rhs_s3));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s2 <= in_valid;
			end
			if (!v_s3 || adv_s3) begin
				v_s3 <= adv_s2;
			end
			if (!m_valid_q || m_tready) begin
				m_valid_q <= adv_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			st_s2  <= in_state;
			thr_s2 <= threshold;
		end
		if (adv_s2) begin
			null_s3    <= st_s2.null_seen;
			ex_zero_s3 <= (st_s2.examined == '0);
			np_s3      <= st_s2.nonprint;
			ex_s3      <= st_s2.examined;
			lhs_s3     <= PROD_W'(st_s2.nonprint) * PROD_W'(PCT_SCALE);
			rhs_s3     <= PROD_W'(thr_s2) * PROD_W'(st_s2.examined);
		end
		if (adv_s3) begin
			m_data_q <= OUT_W'({ex_s3, np_s3, null_s3, text});
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

### design/text_binary_content_classifier_unit.sv
// Channel   Direction  Payload (lowest bit first)
// s_axis    in         tdata: data_byte[7:0]; tuser: byte_present; tlast: last_byte
// m_axis    out        tdata: is_text, null_found, nonprint_total[12:0],
//                      bytes_examined[12:0], zero pad to 32 bits
// cfg       in         cfg_index 0: sample_limit, 1: threshold_percent
//
// One byte is accepted every cycle while no last byte waits for the verdict stage;
// the per-stream counters are registered from the input register. After its last
// transfer a verdict passes counter update, two multiplies and compare stages.
// Reset clears all counters and loads the default limit and threshold.
// An m_tready stall can hold a last byte in the input stage and bytes behind it.
`include "assert_macros.svh"

module text_binary_content_classifier_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [tbcc_pkg::BYTE_W-1:0]       s_tdata,  // data_byte
	input  logic                              s_tuser,  // byte_present
	input  logic                              s_tlast,  // last_byte
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [tbcc_pkg::OUT_W-1:0]        m_tdata,  // is_text, null_found,
	                                                    // nonprint_total, bytes_examined
	input  logic                              cfg_we,
	input  logic [tbcc_pkg::REG_IDX_W-1:0]    cfg_index,
	input  logic [tbcc_pkg::SL_W-1:0]         cfg_data
);
	import tbcc_pkg::*;

	logic [SL_W-1:0]   sample_limit_q;
	logic [THR_W-1:0]  threshold_q;
	logic              v_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              present_s1;
	logic              last_s1;
	stream_state_t     st_q;
	stream_state_t     st_done;
	stream_state_t     st_next;
	logic [LIM_W-1:0]  limit;
	logic              vd_ready;
	logic              adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_limit_q <= SAMPLE_LIMIT_RST;
			threshold_q    <= THRESHOLD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SAMPLE_LIMIT: sample_limit_q <= cfg_data;
				REG_THRESHOLD:    threshold_q    <= cfg_data[THR_W-1:0];
				default:          sample_limit_q <= sample_limit_q;
			endcase
		end
	end

	always_comb begin
		if (sample_limit_q == '0) begin
			limit = LIM_W'(1);
		end else if (LIM_W'(sample_limit_q) > LIM_W'(MAX_SAMPLE)) begin
			limit = LIM_W'(MAX_SAMPLE);
		end else begin
			limit = LIM_W'(sample_limit_q);
		end
	end

	assign adv_s1   = v_s1 && (!last_s1 || vd_ready);
	assign s_tready = !v_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			st_q <= '0;
		end else begin
			if (s_tready) begin
				v_s1 <= s_tvalid;
			end
			if (adv_s1) begin
				st_q <= st_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1    <= s_tdata;
			present_s1 <= s_tuser;
			last_s1    <= s_tlast;
		end
	end

	tbcc_byte_step u_step (
		.st           (st_q),
		.data_byte    (byte_s1),
		.byte_present (present_s1),
		.last_byte    (last_s1),
		.limit        (limit),
		.st_done      (st_done),
		.st_next      (st_next)
	);

	tbcc_verdict u_verdict (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1 && last_s1),
		.in_ready  (vd_ready),
		.in_state  (st_done),
		.threshold (threshold_q),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	`ASSERT_NEVER(a_count_max, clk, arst_n, st_q.examined > CNT_W'(MAX_SAMPLE))
	`ASSERT_NEVER(a_np_le_ex, clk, arst_n, st_q.nonprint > st_q.examined)
	`ASSERT_CLK(a_clear_after_last, clk, arst_n, (adv_s1 && last_s1) |=> (st_q == '0))
	`ASSERT_CLK(a_text_no_nul, clk, arst_n, (m_tvalid && m_tdata[0]) |-> !m_tdata[1])

endmodule

### verif/text_binary_content_classifier_unit_tb.sv
`timescale 1ns / 1ps

module text_binary_content_classifier_unit_tb;
	import tbcc_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int IDLE_LIMIT   = 5000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 10;
	localparam int PHASES       = 8;
	localparam int PHASE_BYTES  = 48;
	localparam int CTRL_RUN     = 39;

	localparam int STYLE_TEXT  = 69;
	localparam int STYLE_MIXED = 95;
	localparam int STYLE_NUL   = 99;

	typedef struct {
		logic             is_text;
		logic             null_found;
		logic [CNT_W-1:0] nonprint_total;
		logic [CNT_W-1:0] bytes_examined;
	} verdict_t;

	class verdict_scoreboard;
		logic [SL_W-1:0]  limit_reg;
		logic [THR_W-1:0] thresh_reg;
		logic [CNT_W-1:0] examined_cnt;
		logic [CNT_W-1:0] nonprint_cnt;
		logic [1:0]       conts_left;
		bit               run_broken;
		bit               nul_hit;
		verdict_t         verdicts_due[$];
		int               faults;

		function void clear_stream();
			examined_cnt = '0;
			nonprint_cnt = '0;
			conts_left = '0;
			run_broken = 1'b0;
			nul_hit = 1'b0;
		endfunction

		function void restart();
			limit_reg = SAMPLE_LIMIT_RST;
			thresh_reg = THRESHOLD_RST;
			faults = 0;
			verdicts_due.delete();
			clear_stream();
		endfunction

		function void set_reg(logic [REG_IDX_W-1:0] idx, logic [SL_W-1:0] value);
			if (idx == REG_SAMPLE_LIMIT) begin
				limit_reg = value;
			end else begin
				thresh_reg = value[THR_W-1:0];
			end
		endfunction

		function int unsigned sample_cap();
			int unsigned cap;
			cap = limit_reg;
			if (cap == 0) begin
				cap = 1;
			end
			if (cap > MAX_SAMPLE) begin
				cap = MAX_SAMPLE;
			end
			return cap;
		endfunction

		function void count_event();
			if (!nul_hit) begin
				nonprint_cnt++;
			end
		endfunction

		function void classify_byte(logic [BYTE_W-1:0] c);
			examined_cnt++;
			if (conts_left != 0) begin
				conts_left--;
				if ((c & CONT_MASK) != CONT_VAL && !run_broken) begin
					run_broken = 1'b1;
					count_event();
				end
			end else begin
				run_broken = 1'b0;
				if (c == CH_NUL) begin
					nul_hit = 1'b1;
				end else if (c < CH_CTRL_END) begin
					if (c != CH_TAB && c != CH_LF && c != CH_CR) begin
						count_event();
					end
				end else if (c >= CH_HIGH) begin
					if ((c & LEAD2_MASK) == LEAD2_VAL) begin
						conts_left = 2'd1;
					end else if ((c & LEAD3_MASK) == LEAD3_VAL) begin
						conts_left = 2'd2;
					end else if ((c & LEAD4_MASK) == LEAD4_VAL) begin
						conts_left = 2'd3;
					end else begin
						count_event();
					end
				end
			end
		endfunction

		function void note_input(logic [BYTE_W-1:0] c, bit present, bit is_last);
			verdict_t v;
			if (present && examined_cnt < sample_cap()) begin
				classify_byte(c);
			end
			if (is_last) begin
				v.null_found = nul_hit;
				v.nonprint_total = nonprint_cnt;
				v.bytes_examined = examined_cnt;
				if (nul_hit) begin
					v.is_text = 1'b0;
				end else if (examined_cnt == 0) begin
					v.is_text = 1'b1;
				end else begin
					v.is_text = int'(nonprint_cnt) * PCT_SCALE <
						int'(thresh_reg) * int'(examined_cnt);
				end
				verdicts_due.insert(verdicts_due.size(), v);
				clear_stream();
			end
		endfunction

		function void check_result(logic [OUT_W-1:0] word);
			verdict_t v;
			logic [CNT_W-1:0] np_got;
			logic [CNT_W-1:0] ex_got;
			np_got = word[2 +: CNT_W];
			ex_got = word[2 + CNT_W +: CNT_W];
			if (verdicts_due.size() == 0) begin
				$error("verdict with none expected: tdata %h", word);
				faults++;
			end else begin
				v = verdicts_due.pop_front();
				if (word[0] !== v.is_text) begin
					$error("is_text: expected %0d, got %0d", v.is_text, word[0]);
					faults++;
				end
				if (word[1] !== v.null_found) begin
					$error("null_found: expected %0d, got %0d", v.null_found, word[1]);
					faults++;
				end
				if (np_got !== v.nonprint_total) begin
					$error("nonprint_total: expected %0d, got %0d", v.nonprint_total, np_got);
					faults++;
				end
				if (ex_got !== v.bytes_examined) begin
					$error("bytes_examined: expected %0d, got %0d", v.bytes_examined, ex_got);
					faults++;
				end
			end
		endfunction

		function int pending();
			return verdicts_due.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [BYTE_W-1:0]    s_tdata;
	logic                 s_tuser;
	logic                 s_tlast;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [OUT_W-1:0]     m_tdata;
	logic                 cfg_we;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [SL_W-1:0]      cfg_data;

	verdict_scoreboard sb;
	int burst_left = 0;
	int bytes_sent = 0;
	int quiet_cycles = 0;
	bit tx_steady = 1'b1;
	bit rx_steady = 1'b1;
	bit hold_toggle = 1'b0;

	text_binary_content_classifier_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	initial begin
		int run_left;
		int hold_left;
		bit level;
		bit hold_seen;
		run_left = 0;
		hold_left = 0;
		level = 1'b1;
		hold_seen = 1'b0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_toggle != hold_seen) begin
				hold_seen = hold_toggle;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready = 1'b0;
			end else begin
				if (run_left == 0) begin
					level = rx_steady || ($urandom_range(0, 3) != 0);
					run_left = level ? $urandom_range(1, 12) : $urandom_range(1, 5);
				end
				run_left--;
				m_tready = level;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_result(m_tdata);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("[text_binary_content_classifier_unit] ERROR");
			$finish;
		end
	end

	task automatic send_item(input logic [BYTE_W-1:0] data, input bit present, input bit is_last);
		int gap;
		if (burst_left == 0) begin
			gap = (tx_steady || $urandom_range(0, 2) != 0) ? 0 : $urandom_range(1, 6);
			repeat (gap) begin
				@(negedge clk);
				s_tvalid = 1'b0;
			end
			burst_left = $urandom_range(1, 24);
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tdata = data;
		s_tuser = present;
		s_tlast = is_last;
		do @(posedge clk); while (!s_tready);
		sb.note_input(data, present, is_last);
		burst_left--;
		if (present) begin
			bytes_sent++;
		end
	endtask

	task automatic settle();
		@(negedge clk);
		s_tvalid = 1'b0;
		burst_left = 0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [SL_W-1:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.set_reg(idx, value);
	endtask

	function automatic void put_byte(ref logic [BYTE_W-1:0] q[$], input logic [BYTE_W-1:0] b);
		q.insert(q.size(), b);
	endfunction

	// Printable text, whitespace, UTF-8 runs (sometimes broken), control bytes,
	// stray high bytes and NUL, in growing amounts of damage with the style.
	function automatic void add_token(ref logic [BYTE_W-1:0] q[$], input int style);
		int r;
		int nc;
		int k;
		r = $urandom_range(0, style);
		if (r < 40) begin
			put_byte(q, BYTE_W'($urandom_range(32, 127)));
		end else if (r < 50) begin
			case ($urandom_range(0, 2))
				0: put_byte(q, CH_TAB);
				1: put_byte(q, CH_LF);
				default: put_byte(q, CH_CR);
			endcase
		end else if (r < 70) begin
			nc = $urandom_range(1, 3);
			case (nc)
				1: put_byte(q, LEAD2_VAL | BYTE_W'($urandom_range(0, 31)));
				2: put_byte(q, LEAD3_VAL | BYTE_W'($urandom_range(0, 15)));
				default: put_byte(q, LEAD4_VAL | BYTE_W'($urandom_range(0, 7)));
			endcase
			k = (style != STYLE_TEXT && $urandom_range(0, 3) == 0) ? $urandom_range(1, nc) : 0;
			for (int i = 1; i <= nc; i++) begin
				if (i == k) begin
					put_byte(q, {$urandom_range(0, 1) ? 2'b11 : 2'b00,
						6'($urandom_range(0, 63))});
				end else begin
					put_byte(q, CONT_VAL | BYTE_W'($urandom_range(0, 63)));
				end
			end
		end else if (r < 80) begin
			put_byte(q, BYTE_W'($urandom_range(1, 31)));
		end else if (r < 90) begin
			put_byte(q, BYTE_W'($urandom_range(128, 255)));
		end else if (r < 96) begin
			put_byte(q, BYTE_W'($urandom_range(0, 255)));
		end else begin
			put_byte(q, CH_NUL);
		end
	endfunction

	task automatic send_stream(input int len, input int style, input bit closed);
		logic [BYTE_W-1:0] q[$];
		bit empty_end;
		empty_end = (len == 0) || ($urandom_range(0, 5) == 0);
		while (q.size() < len) add_token(q, style);
		while (q.size() > len) void'(q.pop_back());
		foreach (q[i]) begin
			if ($urandom_range(0, 9) == 0) begin
				send_item(BYTE_W'($urandom), 1'b0, 1'b0);
			end
			send_item(q[i], 1'b1, closed && !empty_end && i == q.size() - 1);
		end
		if (closed && empty_end) begin
			send_item(BYTE_W'($urandom), 1'b0, 1'b1);
		end
	endtask

	function automatic int pick_len();
		return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 30);
	endfunction

	function automatic int pick_style();
		case ($urandom_range(0, 2))
			0: return STYLE_TEXT;
			1: return STYLE_MIXED;
			default: return STYLE_NUL;
		endcase
	endfunction

	initial begin
		logic [SL_W-1:0] limit_set[PHASES];
		logic [SL_W-1:0] thresh_set[PHASES];
		int start_bytes;
		sb = new();
		sb.restart();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		s_tlast = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_SAMPLE_LIMIT;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Empty stream, ignored item, NUL, control and high bytes, UTF-8 runs
		// good, broken, cut by the end, and a verdict on a byteless last item.
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'h5A, 1'b0, 1'b0);
		send_item(8'h41, 1'b1, 1'b1);
		send_item(CH_NUL, 1'b1, 1'b0);
		send_item(8'h61, 1'b1, 1'b1);
		send_item(CH_TAB, 1'b1, 1'b0);
		send_item(CH_LF, 1'b1, 1'b0);
		send_item(CH_CR, 1'b1, 1'b0);
		send_item(8'h1F, 1'b1, 1'b0);
		send_item(8'h7F, 1'b1, 1'b0);
		send_item(8'hFF, 1'b1, 1'b1);
		send_item(8'hC3, 1'b1, 1'b0);
		send_item(8'hA9, 1'b1, 1'b0);
		send_item(8'hE2, 1'b1, 1'b0);
		send_item(CH_NUL, 1'b1, 1'b0);
		send_item(8'h41, 1'b1, 1'b0);
		send_item(8'hF0, 1'b1, 1'b0);
		send_item(8'h80, 1'b1, 1'b1);
		send_item(8'hF4, 1'b1, 1'b0);
		send_item(8'h41, 1'b1, 1'b0);
		send_item(8'h42, 1'b1, 1'b0);
		send_item(8'h43, 1'b1, 1'b0);
		send_item(8'h80, 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		settle();

		// The receiver holds off while short streams keep arriving.
		tx_steady = 1'b1;
		rx_steady = 1'b0;
		hold_toggle = ~hold_toggle;
		repeat (40) send_stream($urandom_range(0, 2), pick_style(), 1'b1);
		settle();

		limit_set = '{13'd0, 13'd8191, 13'd3, 13'd16, 13'd4096, 13'd1, 13'd40,
			SL_W'($urandom_range(2, 200))};
		thresh_set = '{13'd0, 13'd127, 13'd100, 13'd1, 13'd30, 13'd50, 13'd100,
			SL_W'($urandom_range(0, 127))};
		for (int p = 0; p < PHASES; p++) begin
			write_reg(REG_SAMPLE_LIMIT, limit_set[p]);
			write_reg(REG_THRESHOLD, thresh_set[p]);
			tx_steady = (p % 3 == 0);
			rx_steady = (p % 4 == 1);
			start_bytes = bytes_sent;
			while (bytes_sent - start_bytes < PHASE_BYTES) begin
				send_stream(pick_len(), pick_style(), 1'b1);
			end
			settle();
		end

		// One stream under the largest limit setting, every byte a control byte.
		tx_steady = 1'b1;
		rx_steady = 1'b1;
		write_reg(REG_SAMPLE_LIMIT, 13'd8191);
		write_reg(REG_THRESHOLD, 13'd100);
		repeat (CTRL_RUN) send_item(8'h01, 1'b1, 1'b0);
		send_item(8'h01, 1'b1, 1'b1);
		settle();

		// The limit drops below the count while a stream is open.
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		write_reg(REG_SAMPLE_LIMIT, 13'd20);
		write_reg(REG_THRESHOLD, 13'd30);
		send_stream(10, STYLE_MIXED, 1'b0);
		settle();
		write_reg(REG_SAMPLE_LIMIT, 13'd5);
		send_stream(4, STYLE_MIXED, 1'b1);
		settle();

		if (sb.faults == 0) begin
			$display("[text_binary_content_classifier_unit] OK");
		end else begin
			$display("[text_binary_content_classifier_unit] ERROR");
		end
		$finish;
	end

endmodule
